// ----- design/twtlc_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and helpers for the two-way traffic light controller
// no dependencies; imported by the channel interfaces and the core

package twtlc_pkg;

   // field widths
   localparam int unsigned SecondsWidth = 7;
   localparam int unsigned YellowWidth  = 5;
   localparam int unsigned CountWidth   = 8;
   localparam int unsigned DigitWidth   = 4;

   // configuration port
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] RegWestGreen  = 3'd0;
   localparam logic [2:0] RegSouthGreen = 3'd1;
   localparam logic [2:0] RegYellow     = 3'd2;
   localparam logic [2:0] RegTickRate   = 3'd3;
   localparam logic [2:0] RegThreshold  = 3'd4;
   localparam logic [2:0] RegLockout    = 3'd5;

   // register reset values
   localparam logic [SecondsWidth-1:0] WestGreenReset  = 7'd20;
   localparam logic [SecondsWidth-1:0] SouthGreenReset = 7'd12;
   localparam logic [YellowWidth-1:0]  YellowReset     = 5'd3;
   localparam logic [CountWidth-1:0]   TickRateReset   = 8'd10;
   localparam logic [CountWidth-1:0]   ThresholdReset  = 8'd3;
   localparam logic [CountWidth-1:0]   LockoutReset    = 8'd20;

   localparam logic [SecondsWidth-1:0] DisplayMax = 7'd99;
   localparam logic [CountWidth-1:0]   CountMax   = 8'd255;

   typedef struct packed {
      logic [DigitWidth-1:0] tens;
      logic [DigitWidth-1:0] ones;
   } bcd_pair_type;

   // zero duration acts as one second
   function automatic logic [SecondsWidth-1:0] at_least_one(
      input logic [SecondsWidth-1:0] v);
      return (v == '0) ? SecondsWidth'(1) : v;
   endfunction

   // 0..99 to two bcd digits, tens by reciprocal multiply (x*103 >> 10)
   function automatic bcd_pair_type to_bcd(input logic [SecondsWidth-1:0] v);
      logic [13:0]             prod;
      logic [DigitWidth-1:0]   tens;
      logic [SecondsWidth-1:0] rem;
      bcd_pair_type            res;
      prod     = 14'(v) * 14'd103;
      tens     = prod[13:10];
      rem      = v - 7'(tens) * 7'd10;
      res.tens = tens;
      res.ones = rem[DigitWidth-1:0];
      return res;
   endfunction

endpackage

// ----- design/twtlc_req_if.sv -----
`timescale 1ns / 1ps
// tick channel: valid/ready handshake carrying button level and mode event
// depends on twtlc_pkg

interface twtlc_req_if import twtlc_pkg::*; ();
   logic valid;
   logic ready;
   logic button_level;
   logic mode_event;

   modport source (output valid, output button_level, output mode_event, input ready);
   modport sink   (input valid, input button_level, input mode_event, output ready);
endinterface

// ----- design/twtlc_rsp_if.sv -----
`timescale 1ns / 1ps
// result channel: valid/ready handshake carrying lamps, bcd displays and mode
// depends on twtlc_pkg for the digit width

interface twtlc_rsp_if import twtlc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  south_lamp_red;
   logic                  south_lamp_yellow;
   logic                  south_lamp_green;
   logic                  west_lamp_red;
   logic                  west_lamp_yellow;
   logic                  west_lamp_green;
   logic [DigitWidth-1:0] south_tens;
   logic [DigitWidth-1:0] south_ones;
   logic [DigitWidth-1:0] west_tens;
   logic [DigitWidth-1:0] west_ones;
   logic                  manual_mode;

   modport source (
      output valid, output south_lamp_red, output south_lamp_yellow,
      output south_lamp_green, output west_lamp_red, output west_lamp_yellow,
      output west_lamp_green,
      output south_tens, output south_ones, output west_tens, output west_ones,
      output manual_mode, input ready
   );
   modport sink (
      input valid, input south_lamp_red, input south_lamp_yellow,
      input south_lamp_green, input west_lamp_red, input west_lamp_yellow,
      input west_lamp_green,
      input south_tens, input south_ones, input west_tens, input west_ones,
      input manual_mode, output ready
   );
endinterface

// ----- design/two_way_traffic_light_controller_core.sv -----
`timescale 1ns / 1ps
// two-way traffic light controller core: tick register, per-tick logic, result register
// depends on twtlc_pkg, twtlc_req_if and twtlc_rsp_if
//
// channel   | direction | carries
// ----------+-----------+------------------------------------------------
// req_ch    | in        | one item per 100 ms tick: button_level, mode_event
// rsp_ch    | out       | one item per tick: six lamps, two bcd displays, mode
// apb       | in        | six configuration registers at byte address 4*i
//
// an item passes through the tick register and then the result register;
// one item per cycle sustained while the result side does not stall
// the controller state is updated as an item moves to the result register,
// so the next item sees it with no bubble
// reset (synchronous, active high) empties both stages, restores register
// defaults and starts auto mode at west green; no item is taken during reset
// a stalled result holds; the tick register keeps accepting while the result
// register is free or being drained

module two_way_traffic_light_controller_core
   import twtlc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   twtlc_req_if.sink               req_ch,
   twtlc_rsp_if.source             rsp_ch,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // phase codes
   localparam logic [2:0] PhWestGreen   = 3'd0;
   localparam logic [2:0] PhWestYellow  = 3'd1;
   localparam logic [2:0] PhSouthGreen  = 3'd2;
   localparam logic [2:0] PhSouthYellow = 3'd3;
   localparam logic [2:0] PhManHold     = 3'd4;
   localparam logic [2:0] PhManYellow   = 3'd5;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [SecondsWidth-1:0] west_green_ff;
   logic [SecondsWidth-1:0] south_green_ff;
   logic [YellowWidth-1:0]  yellow_ff;
   logic [CountWidth-1:0]   tick_rate_ff;
   logic [CountWidth-1:0]   threshold_ff;
   logic [CountWidth-1:0]   lockout_limit_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CsrAddrWidth-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         west_green_ff    <= WestGreenReset;
         south_green_ff   <= SouthGreenReset;
         yellow_ff        <= YellowReset;
         tick_rate_ff     <= TickRateReset;
         threshold_ff     <= ThresholdReset;
         lockout_limit_ff <= LockoutReset;
      end else if (csr_write) begin
         unique case (csr_index)
            RegWestGreen:  west_green_ff    <= pwdata[SecondsWidth-1:0];
            RegSouthGreen: south_green_ff   <= pwdata[SecondsWidth-1:0];
            RegYellow:     yellow_ff        <= pwdata[YellowWidth-1:0];
            RegTickRate:   tick_rate_ff     <= pwdata[CountWidth-1:0];
            RegThreshold:  threshold_ff     <= pwdata[CountWidth-1:0];
            RegLockout:    lockout_limit_ff <= pwdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         unique case (csr_index)
            RegWestGreen:  prdata = CsrDataWidth'(west_green_ff);
            RegSouthGreen: prdata = CsrDataWidth'(south_green_ff);
            RegYellow:     prdata = CsrDataWidth'(yellow_ff);
            RegTickRate:   prdata = CsrDataWidth'(tick_rate_ff);
            RegThreshold:  prdata = CsrDataWidth'(threshold_ff);
            RegLockout:    prdata = CsrDataWidth'(lockout_limit_ff);
            default:       prdata = '0;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline control: tick register -> result register
   // ---------------------------------------------------------------
   logic tick_valid_ff;
   logic tick_button_ff;
   logic tick_event_ff;
   logic rsp_valid_ff;
   logic advance;

   // the tick item moves on when the result register is empty or draining
   assign advance      = tick_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!tick_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         tick_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         tick_button_ff <= req_ch.button_level;
         tick_event_ff  <= req_ch.mode_event;
      end
   end

   // ---------------------------------------------------------------
   // controller state
   // ---------------------------------------------------------------
   logic                    mode_ff,       mode_in;
   logic                    side_ff,       side_in;
   logic [2:0]              phase_ff,      phase_in;
   logic [SecondsWidth-1:0] seconds_ff,    seconds_in;
   logic [CountWidth-1:0]   tick_count_ff, tick_count_in;
   logic [CountWidth-1:0]   press_ff,      press_in;
   logic                    lock_ff,       lock_in;
   logic [CountWidth-1:0]   lock_count_ff, lock_count_in;

   // per-tick intermediates
   logic                    toggle;
   logic                    lock_mid;
   logic [SecondsWidth-1:0] yellow_secs;
   logic [SecondsWidth-1:0] west_secs;
   logic [SecondsWidth-1:0] south_secs;
   logic [CountWidth-1:0]   seconds_plus_y;
   logic [CountWidth-1:0]   sdisp_raw;
   logic [CountWidth-1:0]   wdisp_raw;
   logic [SecondsWidth-1:0] sdisp;
   logic [SecondsWidth-1:0] wdisp;
   logic [5:0]              lamps;    // sr sy sg wr wy wg
   logic [CountWidth-1:0]   press_step;
   logic                    pressed;
   logic [CountWidth:0]     lock_next;
   logic [CountWidth:0]     tick_inc;
   logic [SecondsWidth-1:0] seconds_dec;
   bcd_pair_type            south_bcd;
   bcd_pair_type            west_bcd;

   assign yellow_secs    = at_least_one(SecondsWidth'(yellow_ff));
   assign west_secs      = at_least_one(west_green_ff);
   assign south_secs     = at_least_one(south_green_ff);
   assign seconds_plus_y = CountWidth'(seconds_ff) + CountWidth'(yellow_secs);

   // mode event first: ignored while the lockout runs
   assign toggle   = tick_event_ff && !lock_ff;
   assign mode_in  = mode_ff ^ toggle;
   assign lock_mid = lock_ff || toggle;

   // lamps and raw displays from the phase at the start of the tick
   always_comb begin
      lamps     = '0;
      sdisp_raw = '0;
      wdisp_raw = '0;
      unique case (phase_ff)
         PhWestYellow: begin
            lamps     = 6'b100_010;
            sdisp_raw = CountWidth'(seconds_ff);
            wdisp_raw = CountWidth'(seconds_ff);
         end
         PhSouthGreen: begin
            lamps     = 6'b001_100;
            sdisp_raw = CountWidth'(seconds_ff);
            wdisp_raw = seconds_plus_y;
         end
         PhSouthYellow: begin
            lamps     = 6'b010_100;
            sdisp_raw = CountWidth'(seconds_ff);
            wdisp_raw = CountWidth'(seconds_ff);
         end
         PhManHold: begin
            // displays show zero while a road is held green
            lamps = side_ff ? 6'b001_100 : 6'b100_001;
         end
         PhManYellow: begin
            // only the yellow side counts down
            if (side_ff) begin
               lamps     = 6'b010_100;
               sdisp_raw = CountWidth'(seconds_ff);
            end else begin
               lamps     = 6'b100_010;
               wdisp_raw = CountWidth'(seconds_ff);
            end
         end
         default: begin
            // west green, and unused codes behave alike
            lamps     = 6'b100_001;
            wdisp_raw = CountWidth'(seconds_ff);
            sdisp_raw = seconds_plus_y;
         end
      endcase
   end

   // saturate displays to 0..99
   assign sdisp = (sdisp_raw > CountWidth'(DisplayMax)) ? DisplayMax
                                                        : sdisp_raw[SecondsWidth-1:0];
   assign wdisp = (wdisp_raw > CountWidth'(DisplayMax)) ? DisplayMax
                                                        : wdisp_raw[SecondsWidth-1:0];
   assign south_bcd = to_bcd(sdisp);
   assign west_bcd  = to_bcd(wdisp);

   // debounce: up while pressed (low), down while released, clear on threshold
   always_comb begin
      if (!tick_button_ff) begin
         press_step = (press_ff != CountMax) ? press_ff + 8'd1 : press_ff;
      end else begin
         press_step = (press_ff != '0) ? press_ff - 8'd1 : press_ff;
      end
      pressed  = press_step >= threshold_ff;
      press_in = pressed ? '0 : press_step;
   end

   // lockout counter already counts in the tick that starts it
   always_comb begin
      lock_next     = {1'b0, lock_count_ff} + 9'd1;
      lock_in       = lock_mid;
      lock_count_in = lock_count_ff;
      if (lock_mid) begin
         if (lock_next > {1'b0, lockout_limit_ff}) begin
            lock_count_in = '0;
            lock_in       = 1'b0;
         end else begin
            lock_count_in = lock_next[CountWidth-1:0];
         end
      end
   end

   // phase advance
   always_comb begin
      tick_inc      = {1'b0, tick_count_ff} + 9'd1;
      seconds_dec   = seconds_ff - 7'd1;
      phase_in      = phase_ff;
      seconds_in    = seconds_ff;
      tick_count_in = tick_count_ff;
      side_in       = side_ff;
      if (phase_ff == PhManHold) begin
         // a press wins over a return to auto
         if (pressed) begin
            phase_in      = PhManYellow;
            seconds_in    = yellow_secs;
            tick_count_in = '0;
         end else if (!mode_in) begin
            phase_in      = PhWestGreen;
            seconds_in    = west_secs;
            tick_count_in = '0;
         end
      end else if (phase_ff > PhManYellow) begin
         phase_in      = PhWestGreen;
         seconds_in    = west_secs;
         tick_count_in = '0;
      end else if (tick_inc >= {1'b0, tick_rate_ff}) begin
         // one whole second gone
         tick_count_in = '0;
         seconds_in    = seconds_dec;
         if (seconds_dec == '0) begin
            unique case (phase_ff)
               PhWestGreen: begin
                  phase_in   = PhWestYellow;
                  seconds_in = yellow_secs;
               end
               PhWestYellow: begin
                  phase_in   = PhSouthGreen;
                  seconds_in = south_secs;
               end
               PhSouthGreen: begin
                  phase_in   = PhSouthYellow;
                  seconds_in = yellow_secs;
               end
               PhManYellow: begin
                  side_in = ~side_ff;
                  if (mode_in) begin
                     phase_in = PhManHold;
                  end else begin
                     phase_in   = PhWestGreen;
                     seconds_in = west_secs;
                  end
               end
               default: begin
                  // end of south yellow: mode change seen here
                  if (mode_in) begin
                     phase_in = PhManHold;
                  end else begin
                     phase_in   = PhWestGreen;
                     seconds_in = west_secs;
                  end
               end
            endcase
         end
      end else begin
         tick_count_in = tick_inc[CountWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         side_ff       <= 1'b0;
         phase_ff      <= PhWestGreen;
         seconds_ff    <= WestGreenReset;
         tick_count_ff <= '0;
         press_ff      <= '0;
         lock_ff       <= 1'b0;
         lock_count_ff <= '0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         side_ff       <= side_in;
         phase_ff      <= phase_in;
         seconds_ff    <= seconds_in;
         tick_count_ff <= tick_count_in;
         press_ff      <= press_in;
         lock_ff       <= lock_in;
         lock_count_ff <= lock_count_in;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   logic [5:0]   lamps_ff;
   bcd_pair_type south_bcd_ff;
   bcd_pair_type west_bcd_ff;
   logic         manual_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lamps_ff     <= lamps;
         south_bcd_ff <= south_bcd;
         west_bcd_ff  <= west_bcd;
         manual_ff    <= mode_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.south_lamp_red    = lamps_ff[5];
   assign rsp_ch.south_lamp_yellow = lamps_ff[4];
   assign rsp_ch.south_lamp_green  = lamps_ff[3];
   assign rsp_ch.west_lamp_red     = lamps_ff[2];
   assign rsp_ch.west_lamp_yellow  = lamps_ff[1];
   assign rsp_ch.west_lamp_green   = lamps_ff[0];
   assign rsp_ch.south_tens        = south_bcd_ff.tens;
   assign rsp_ch.south_ones        = south_bcd_ff.ones;
   assign rsp_ch.west_tens         = west_bcd_ff.tens;
   assign rsp_ch.west_ones         = west_bcd_ff.ones;
   assign rsp_ch.manual_mode       = manual_ff;

endmodule

// ----- bench/tb_two_way_traffic_light_controller_core.sv -----
`timescale 1ns / 1ps
// self-checking bench for two_way_traffic_light_controller_core: ticks in, lamps and displays out
// depends on twtlc_pkg, twtlc_req_if, twtlc_rsp_if and the core itself

module tb_two_way_traffic_light_controller_core;
   import twtlc_pkg::*;

   localparam int unsigned CycleLimit      = 400_000;
   localparam int unsigned ItemsPerSetting = 134;
   localparam int unsigned NumSettings     = 9;

   // controller phases as the predictor walks them
   typedef enum logic [2:0] {
      PhWestGreen, PhWestYellow, PhSouthGreen, PhSouthYellow, PhManualHold, PhManualYellow
   } light_phase_type;

   typedef struct packed {
      logic                  south_lamp_red;
      logic                  south_lamp_yellow;
      logic                  south_lamp_green;
      logic                  west_lamp_red;
      logic                  west_lamp_yellow;
      logic                  west_lamp_green;
      logic [DigitWidth-1:0] south_tens;
      logic [DigitWidth-1:0] south_ones;
      logic [DigitWidth-1:0] west_tens;
      logic [DigitWidth-1:0] west_ones;
      logic                  manual_mode;
   } light_result_type;

   typedef enum logic {RowTick, RowWrite} row_kind_type;

   // one line of the directed part: a register write or a run of identical ticks
   typedef struct packed {
      row_kind_type     kind;
      logic [2:0]       reg_index;
      logic [31:0]      value;
      logic             btn;
      logic             ev;
      logic [7:0]       reps;
      logic             typed;
      light_result_type want;
   } script_row_type;

   // first tick after reset: west green 20 s, south red shows 20 + 3
   localparam light_result_type AfterReset = '{south_lamp_red: 1'b1, west_lamp_green: 1'b1,
      south_tens: 4'd2, south_ones: 4'd3, west_tens: 4'd2, west_ones: 4'd0, default: '0};
   // mode event accepted, still west green at 20 s, yellow of 0 counts as 1
   localparam light_result_type ModeToManual = '{south_lamp_red: 1'b1, west_lamp_green: 1'b1,
      south_tens: 4'd2, south_ones: 4'd1, west_tens: 4'd2, west_ones: 4'd0,
      manual_mode: 1'b1, default: '0};
   // manual hold on the west road: both displays show zero
   localparam light_result_type ManualHoldWest = '{south_lamp_red: 1'b1,
      west_lamp_green: 1'b1, manual_mode: 1'b1, default: '0};

   localparam int unsigned NumRows = 16;
   localparam script_row_type DirectedScript [NumRows] = '{
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b0, 8'd1,  1'b1, AfterReset},
      // one tick per second, zero west green and yellow, short debounce, one-tick lockout
      '{RowWrite, RegTickRate,   32'd1, 1'b1, 1'b0, 8'd0,  1'b0, '0},
      '{RowWrite, RegWestGreen,  32'd0, 1'b1, 1'b0, 8'd0,  1'b0, '0},
      '{RowWrite, RegSouthGreen, 32'd1, 1'b1, 1'b0, 8'd0,  1'b0, '0},
      '{RowWrite, RegYellow,     32'd0, 1'b1, 1'b0, 8'd0,  1'b0, '0},
      '{RowWrite, RegThreshold,  32'd2, 1'b1, 1'b0, 8'd0,  1'b0, '0},
      '{RowWrite, RegLockout,    32'd0, 1'b1, 1'b0, 8'd0,  1'b0, '0},
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b1, 8'd1,  1'b1, ModeToManual},
      // lockout already over, so these toggle back and forth
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b1, 8'd1,  1'b0, '0},
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b1, 8'd1,  1'b0, '0},
      // presses during the auto cycle are thrown away
      '{RowTick,  RegWestGreen,  32'd0, 1'b0, 1'b0, 8'd4,  1'b0, '0},
      // run out the auto cycle, manual takes over at its end
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b0, 8'd16, 1'b0, '0},
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b0, 8'd1,  1'b1, ManualHoldWest},
      '{RowTick,  RegWestGreen,  32'd0, 1'b0, 1'b0, 8'd1,  1'b0, '0},
      // press and return to auto in the same tick: the press wins
      '{RowTick,  RegWestGreen,  32'd0, 1'b0, 1'b1, 8'd1,  1'b0, '0},
      // manual yellow finishes, then auto restarts at west green
      '{RowTick,  RegWestGreen,  32'd0, 1'b1, 1'b0, 8'd3,  1'b0, '0}
   };

   logic clock;
   logic reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   twtlc_req_if req_ch ();
   twtlc_rsp_if rsp_ch ();

   two_way_traffic_light_controller_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // register copies the predictor works from
   logic [SecondsWidth-1:0] cfg_west_green;
   logic [SecondsWidth-1:0] cfg_south_green;
   logic [YellowWidth-1:0]  cfg_yellow;
   logic [CountWidth-1:0]   cfg_tick_rate;
   logic [CountWidth-1:0]   cfg_threshold;
   logic [CountWidth-1:0]   cfg_lockout;

   // controller state as the predictor sees it
   light_phase_type         lit_phase;
   logic                    manual_on;
   logic                    south_side;
   logic [SecondsWidth-1:0] secs_left;
   logic [CountWidth-1:0]   tick_in_sec;
   logic [CountWidth-1:0]   press_level;
   logic                    lock_on;
   logic [CountWidth-1:0]   lock_count;

   light_result_type expected_lights [$];

   int unsigned error_count   = 0;
   int unsigned ticks_sent    = 0;
   int unsigned manual_seen   = 0;
   int unsigned settings_done = 0;
   int unsigned cycle_count   = 0;
   bit          quiet_tail    = 1'b0;
   bit          gaps_on       = 1'b1;
   bit          stalls_on     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d items still expected",
                  cycle_count, expected_lights.size());
         $display("FAIL two_way_traffic_light_controller_core");
         $finish;
      end
   end

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endfunction

   function automatic string fmt_lights(light_result_type r);
      return $sformatf("s rgy %0b%0b%0b w rgy %0b%0b%0b south %0d%0d west %0d%0d manual %0b",
         r.south_lamp_red, r.south_lamp_green, r.south_lamp_yellow, r.west_lamp_red,
         r.west_lamp_green, r.west_lamp_yellow, r.south_tens, r.south_ones,
         r.west_tens, r.west_ones, r.manual_mode);
   endfunction

   // new phase with a fresh second count; a zero duration lasts one second
   function automatic void enter_phase(light_phase_type next,
                                       logic [SecondsWidth-1:0] secs);
      lit_phase   = next;
      secs_left   = (secs == '0) ? SecondsWidth'(1) : secs;
      tick_in_sec = '0;
   endfunction

   // one tick through the controller: lamps and displays from the phase at its start,
   // then debounce, lockout and the phase move
   function automatic light_result_type step_lights(logic btn, logic ev);
      light_result_type res;
      int unsigned      sdisp;
      int unsigned      wdisp;
      int unsigned      yel;
      int unsigned      nxt;
      logic             pressed;
      res   = '0;
      sdisp = 0;
      wdisp = 0;
      yel   = (cfg_yellow == '0) ? 32'd1 : 32'(cfg_yellow);

      if (ev && !lock_on) begin
         manual_on = !manual_on;
         lock_on   = 1'b1;
      end

      case (lit_phase)
         PhWestYellow: begin
            res.south_lamp_red   = 1'b1;
            res.west_lamp_yellow = 1'b1;
            sdisp                = 32'(secs_left);
            wdisp                = 32'(secs_left);
         end
         PhSouthGreen: begin
            res.south_lamp_green = 1'b1;
            res.west_lamp_red    = 1'b1;
            sdisp                = 32'(secs_left);
            wdisp                = 32'(secs_left) + yel;
         end
         PhSouthYellow: begin
            res.south_lamp_yellow = 1'b1;
            res.west_lamp_red     = 1'b1;
            sdisp                 = 32'(secs_left);
            wdisp                 = 32'(secs_left);
         end
         PhManualHold: begin
            if (south_side) begin
               res.south_lamp_green = 1'b1;
               res.west_lamp_red    = 1'b1;
            end else begin
               res.south_lamp_red  = 1'b1;
               res.west_lamp_green = 1'b1;
            end
         end
         PhManualYellow: begin
            if (south_side) begin
               res.south_lamp_yellow = 1'b1;
               res.west_lamp_red     = 1'b1;
               sdisp                 = 32'(secs_left);
            end else begin
               res.south_lamp_red   = 1'b1;
               res.west_lamp_yellow = 1'b1;
               wdisp                = 32'(secs_left);
            end
         end
         default: begin
            res.south_lamp_red  = 1'b1;
            res.west_lamp_green = 1'b1;
            wdisp               = 32'(secs_left);
            sdisp               = 32'(secs_left) + yel;
         end
      endcase
      if (sdisp > 99) sdisp = 99;
      if (wdisp > 99) wdisp = 99;
      res.south_tens  = DigitWidth'(sdisp / 10);
      res.south_ones  = DigitWidth'(sdisp % 10);
      res.west_tens   = DigitWidth'(wdisp / 10);
      res.west_ones   = DigitWidth'(wdisp % 10);
      res.manual_mode = manual_on;

      // up/down debounce, saturating at both ends
      if (!btn) begin
         if (press_level != CountMax) press_level++;
      end else if (press_level != '0) begin
         press_level--;
      end
      pressed = (press_level >= cfg_threshold);
      if (pressed) press_level = '0;

      if (lock_on) begin
         nxt = 32'(lock_count) + 32'd1;
         if (nxt > 32'(cfg_lockout)) begin
            lock_count = '0;
            lock_on    = 1'b0;
         end else begin
            lock_count = CountWidth'(nxt);
         end
      end

      if (lit_phase == PhManualHold) begin
         if (pressed) enter_phase(PhManualYellow, SecondsWidth'(cfg_yellow));
         else if (!manual_on) enter_phase(PhWestGreen, cfg_west_green);
      end else if (int'(tick_in_sec) + 1 >= int'(cfg_tick_rate)) begin
         tick_in_sec = '0;
         secs_left   = secs_left - SecondsWidth'(1);
         if (secs_left == '0) begin
            case (lit_phase)
               PhWestGreen:  enter_phase(PhWestYellow, SecondsWidth'(cfg_yellow));
               PhWestYellow: enter_phase(PhSouthGreen, cfg_south_green);
               PhSouthGreen: enter_phase(PhSouthYellow, SecondsWidth'(cfg_yellow));
               default: begin
                  // end of the auto cycle or of a manual yellow
                  if (lit_phase == PhManualYellow) south_side = !south_side;
                  if (manual_on) begin
                     lit_phase   = PhManualHold;
                     tick_in_sec = '0;
                  end else begin
                     enter_phase(PhWestGreen, cfg_west_green);
                  end
               end
            endcase
         end
      end else begin
         tick_in_sec++;
      end
      return res;
   endfunction

   // offer one tick, possibly after an idle burst, and log what it must produce
   task automatic send_tick(input logic btn, input logic ev, input logic use_want,
                            input light_result_type want);
      light_result_type predicted;
      if (!quiet_tail && gaps_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.button_level <= btn;
      req_ch.mode_event   <= ev;
      do @(posedge clock); while (!req_ch.ready);
      predicted = step_lights(btn, ev);
      expected_lights.push_back(use_want ? want : predicted);
      ticks_sent++;
   endtask

   // stop offering ticks and let every result come home before touching registers
   task automatic drain_ticks();
      req_ch.valid <= 1'b0;
      while (expected_lights.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write followed by a read of the same register
   task automatic csr_write(input logic [2:0] idx, input logic [CsrDataWidth-1:0] value);
      logic [CsrDataWidth-1:0] stored;
      case (idx)
         RegWestGreen: begin
            cfg_west_green = value[SecondsWidth-1:0];
            stored         = CsrDataWidth'(cfg_west_green);
         end
         RegSouthGreen: begin
            cfg_south_green = value[SecondsWidth-1:0];
            stored          = CsrDataWidth'(cfg_south_green);
         end
         RegYellow: begin
            cfg_yellow = value[YellowWidth-1:0];
            stored     = CsrDataWidth'(cfg_yellow);
         end
         RegTickRate: begin
            cfg_tick_rate = value[CountWidth-1:0];
            stored        = CsrDataWidth'(cfg_tick_rate);
         end
         RegThreshold: begin
            cfg_threshold = value[CountWidth-1:0];
            stored        = CsrDataWidth'(cfg_threshold);
         end
         default: begin
            cfg_lockout = value[CountWidth-1:0];
            stored      = CsrDataWidth'(cfg_lockout);
         end
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrWidth'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // write lands here; psel stays up into the read setup
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== stored)
         flag_error($sformatf("register %0d reads 0x%0h, wrote 0x%0h", idx, prdata, stored));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // one register setting per random stretch: floors, zeros, field maxima, edge mixes, then small random mixes
   task automatic apply_setting(input int unsigned which);
      logic [SecondsWidth-1:0] wg;
      logic [SecondsWidth-1:0] sg;
      logic [YellowWidth-1:0]  yl;
      logic [CountWidth-1:0]   tr;
      logic [CountWidth-1:0]   th;
      logic [CountWidth-1:0]   lk;
      case (which)
         0: {wg, sg, yl, tr, th, lk} = {7'd1, 7'd1, 5'd1, 8'd1, 8'd1, 8'd1};
         1: {wg, sg, yl, tr, th, lk} = {7'd0, 7'd0, 5'd0, 8'd0, 8'd0, 8'd0};
         2: {wg, sg, yl, tr, th, lk} = {7'd127, 7'd127, 5'd31, 8'd1, 8'd255, 8'd255};
         3: {wg, sg, yl, tr, th, lk} = {7'd99, 7'd99, 5'd20, 8'd1, 8'd1, 8'd1};
         4: {wg, sg, yl, tr, th, lk} = {7'd1, 7'd2, 5'd1, 8'd255, 8'd2, 8'd3};
         default: begin
            wg = SecondsWidth'($urandom_range(0, 6));
            sg = SecondsWidth'($urandom_range(0, 6));
            yl = YellowWidth'($urandom_range(0, 3));
            tr = CountWidth'($urandom_range(0, 3));
            th = CountWidth'($urandom_range(0, 5));
            lk = CountWidth'($urandom_range(0, 12));
         end
      endcase
      drain_ticks();
      csr_write(RegWestGreen, CsrDataWidth'(wg));
      csr_write(RegSouthGreen, CsrDataWidth'(sg));
      csr_write(RegYellow, CsrDataWidth'(yl));
      csr_write(RegTickRate, CsrDataWidth'(tr));
      csr_write(RegThreshold, CsrDataWidth'(th));
      csr_write(RegLockout, CsrDataWidth'(lk));
      settings_done++;
   endtask

   // result side: random stall bursts, switched off now and then and for the tail
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_count % 256 == 0) stalls_on = ($urandom_range(0, 3) != 0);
         if (stall_left != 0) stall_left--;
         else if (!quiet_tail && stalls_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 12);
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   // every accepted result is matched against the oldest expected one
   always @(posedge clock) begin : check_result
      light_result_type got;
      light_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{south_lamp_red: rsp_ch.south_lamp_red,
                 south_lamp_yellow: rsp_ch.south_lamp_yellow,
                 south_lamp_green: rsp_ch.south_lamp_green,
                 west_lamp_red: rsp_ch.west_lamp_red,
                 west_lamp_yellow: rsp_ch.west_lamp_yellow,
                 west_lamp_green: rsp_ch.west_lamp_green,
                 south_tens: rsp_ch.south_tens, south_ones: rsp_ch.south_ones,
                 west_tens: rsp_ch.west_tens, west_ones: rsp_ch.west_ones,
                 manual_mode: rsp_ch.manual_mode};
         if (got.manual_mode === 1'b1) manual_seen++;
         if (expected_lights.size() == 0) begin
            flag_error($sformatf("result with nothing expected: %s", fmt_lights(got)));
         end else begin
            want = expected_lights.pop_front();
            if (got !== want)
               flag_error($sformatf("tick result mismatch\n  expected %s\n  actual   %s",
                                    fmt_lights(want), fmt_lights(got)));
         end
      end
   end

   // stimulus: reset, directed script, then random stretches per register setting
   initial begin
      int unsigned   n;
      int unsigned   run_left;
      int unsigned   burst_left;
      logic          pressing;
      logic          btn;
      logic          ev;
      run_left   = 0;
      burst_left = 0;
      pressing   = 1'b0;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.button_level <= 1'b1;
      req_ch.mode_event   <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;

      // reset view of registers and controller
      cfg_west_green  = WestGreenReset;
      cfg_south_green = SouthGreenReset;
      cfg_yellow      = YellowReset;
      cfg_tick_rate   = TickRateReset;
      cfg_threshold   = ThresholdReset;
      cfg_lockout     = LockoutReset;
      lit_phase       = PhWestGreen;
      manual_on       = 1'b0;
      south_side      = 1'b0;
      secs_left       = WestGreenReset;
      tick_in_sec     = '0;
      press_level     = '0;
      lock_on         = 1'b0;
      lock_count      = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedScript[r]) begin
         if (DirectedScript[r].kind == RowWrite) begin
            drain_ticks();
            csr_write(DirectedScript[r].reg_index, DirectedScript[r].value);
         end else begin
            repeat (DirectedScript[r].reps)
               send_tick(DirectedScript[r].btn, DirectedScript[r].ev,
                         DirectedScript[r].typed, DirectedScript[r].want);
         end
      end

      for (int unsigned s = 0; s < NumSettings; s++) begin
         // no idling on either side for the final stretch
         if (s == NumSettings - 1) quiet_tail = 1'b1;
         apply_setting(s);
         for (n = 0; n < ItemsPerSetting; n++) begin
            if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            // button as alternating press and release runs, press runs near the threshold
            if (run_left == 0) begin
               pressing = !pressing;
               run_left = pressing ? $urandom_range(1, int'(cfg_threshold) + 2)
                                   : $urandom_range(1, 10);
            end
            run_left--;
            btn = ($urandom_range(0, 9) == 0) ? 1'($urandom) : !pressing;
            // sparse mode events, with the odd burst that runs into the lockout
            if (burst_left != 0) begin
               ev = 1'b1;
               burst_left--;
            end else if ($urandom_range(0, 59) == 0) begin
               ev         = 1'b1;
               burst_left = $urandom_range(2, 7);
            end else begin
               ev = ($urandom_range(0, 13) == 0);
            end
            send_tick(btn, ev, 1'b0, '0);
         end
      end

      drain_ticks();
      repeat (8) @(posedge clock);
      if (expected_lights.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_lights.size()));
      $display("%0d ticks checked over %0d register settings plus the directed script",
               ticks_sent, settings_done);
      $display("%0d results in manual mode, %0d errors", manual_seen, error_count);
      if (error_count == 0) begin
         $display("PASS two_way_traffic_light_controller_core");
      end else begin
         $display("FAIL two_way_traffic_light_controller_core");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/twtlc_pkg.sv
design/twtlc_req_if.sv
design/twtlc_rsp_if.sv
design/two_way_traffic_light_controller_core.sv
bench/tb_two_way_traffic_light_controller_core.sv
